// File: hdl/set_assoc_lru_writeback_cache_tags_macros.svh
// ----------------------------------------------------------------------------
// Cache tag directory assertion macros
// Shared implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_TAGS_MACROS_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_TAGS_MACROS_SVH

// same-cycle implication
`define SALRU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SALRU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/salru_pkg.sv
// ----------------------------------------------------------------------------
// Cache tag directory package
// Defaults, field widths, access codes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package salru_pkg;

   localparam int WAYS_DEFAULT      = 4;
   localparam int SETS_DEFAULT      = 256;
   localparam int TAG_WIDTH_DEFAULT = 20;

   localparam int SET_INDEX_WIDTH = 8;
   localparam int WAY_OUT_WIDTH   = 2;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   typedef enum logic [0:0] {
      ST_CLEAR,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic hit;
      logic dirty;
   } status_type;

endpackage

`default_nettype wire

// File: hdl/set_assoc_lru_writeback_cache_tags.sv
// ----------------------------------------------------------------------------
// Set-associative write-back cache tag directory
// True-LRU tag, valid and dirty directory with one lookup per cycle while busy is low.
// ----------------------------------------------------------------------------
// Usage:
//   Request: req_func (0 read, 1 write), req_tag, req_set_index. An item is
//   taken on a rising edge with start high and busy low. Set indexes wrap
//   modulo SETS.
//   Response: rsp_hit, rsp_dirty, rsp_way, valid for the single cycle in
//   which rsp_strobe is high. The receiver cannot stall the block.
//   Timing: the accepting edge registers the request and reads the set row;
//   the lookup and update then go into the result register, which drives
//   the response onto the ports.
//   Throughput: one item per cycle while busy is low, set by the single read
//   port and single write port of the row memory; back-to-back items to the
//   same set are served by a one-entry bypass of the row just written.
//   Reset: after reset is released, a clearing pass writes every set row,
//   one row per cycle; busy is high during that pass.
//   Tags read back only after a miss wrote them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_writeback_cache_tags
   import salru_pkg::*;
#(
   parameter int WAYS      = WAYS_DEFAULT,
   parameter int SETS      = SETS_DEFAULT,
   parameter int TAG_WIDTH = TAG_WIDTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output      logic                       busy,
   input  wire logic                       req_func,
   input  wire logic [TAG_WIDTH-1:0]       req_tag,
   input  wire logic [SET_INDEX_WIDTH-1:0] req_set_index,
   output      logic                       rsp_strobe,
   output      logic                       rsp_hit,
   output      logic                       rsp_dirty,
   output      logic [WAY_OUT_WIDTH-1:0]   rsp_way
);

   localparam int WAY_W         = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SET_W         = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int ROW_W         = WAYS * (TAG_WIDTH + 2 + WAY_W);
   localparam int LRU_LSB       = WAYS * (TAG_WIDTH + 2);
   localparam int SET_MAP_DEPTH = 1 << SET_INDEX_WIDTH;

   state_type state_ff;
   state_type state_in;

   logic [SET_W-1:0] clr_addr_ff;
   logic             clr_last;
   logic             clr_we;
   logic             accept;

   logic [SET_W-1:0] set_map [SET_MAP_DEPTH];
   logic [SET_W-1:0] req_set;

   logic                 s1_valid_ff;
   logic                 s1_func_ff;
   logic [TAG_WIDTH-1:0] s1_tag_ff;
   logic [SET_W-1:0]     s1_set_ff;
   logic                 byp_ff;
   logic [ROW_W-1:0]     byp_row_ff;

   logic [ROW_W-1:0] ram_q;
   logic [ROW_W-1:0] cur_row;
   logic [ROW_W-1:0] new_row;
   logic [ROW_W-1:0] clear_row;
   logic             wr_en;
   logic [SET_W-1:0] wr_addr;
   logic [ROW_W-1:0] wr_data;

   status_type       lk_status;
   logic [WAY_W-1:0] lk_way;

   logic                     rsp_strobe_ff;
   logic                     rsp_hit_ff;
   logic                     rsp_dirty_ff;
   logic [WAY_OUT_WIDTH-1:0] rsp_way_ff;

   for (genvar i = 0; i < SET_MAP_DEPTH; i++) begin : g_set_map
      assign set_map[i] = SET_W'(i % SETS);
   end
   assign req_set = set_map[req_set_index];

   // reset row: invalid, clean, position p holds way WAYS-1-p
   always_comb begin
      clear_row = '0;
      for (int p = 0; p < WAYS; p++) begin
         clear_row[LRU_LSB + p*WAY_W +: WAY_W] = WAY_W'(WAYS - 1 - p);
      end
   end

   assign clr_last = (clr_addr_ff == SET_W'(SETS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      busy   = 1'b0;
      clr_we = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            busy   = 1'b1;
            clr_we = 1'b1;
         end
         ST_RUN: begin
            busy   = 1'b0;
            clr_we = 1'b0;
         end
         default: begin
            busy   = 1'b1;
            clr_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clr_we && !clr_last) begin
            clr_addr_ff <= clr_addr_ff + SET_W'(1);
         end
      end
   end

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= accept;
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff <= req_func;
         s1_tag_ff  <= req_tag;
         s1_set_ff  <= req_set;
         byp_ff     <= s1_valid_ff && (s1_set_ff == req_set);
         byp_row_ff <= new_row;
      end
      if (s1_valid_ff) begin
         rsp_hit_ff   <= lk_status.hit;
         rsp_dirty_ff <= lk_status.dirty;
         rsp_way_ff   <= WAY_OUT_WIDTH'(lk_way);
      end
   end

   assign wr_en   = clr_we || s1_valid_ff;
   assign wr_addr = clr_we ? clr_addr_ff : s1_set_ff;
   assign wr_data = clr_we ? clear_row : new_row;

   salru_row_ram #(
      .DEPTH  (SETS),
      .WIDTH  (ROW_W),
      .ADDR_W (SET_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (ram_q)
   );

   // row written in the cycle of the read is taken from the bypass
   assign cur_row = byp_ff ? byp_row_ff : ram_q;

   salru_lookup #(
      .WAYS      (WAYS),
      .TAG_WIDTH (TAG_WIDTH),
      .WAY_W     (WAY_W),
      .ROW_W     (ROW_W)
   ) u_lookup (
      .row_in  (cur_row),
      .func    (s1_func_ff),
      .tag     (s1_tag_ff),
      .row_out (new_row),
      .status  (lk_status),
      .way     (lk_way)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_dirty  = rsp_dirty_ff;
   assign rsp_way    = rsp_way_ff;

endmodule

`default_nettype wire

// File: hdl/salru_row_ram.sv
// ----------------------------------------------------------------------------
// Directory row memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salru_row_ram #(
   parameter int DEPTH  = 256,
   parameter int WIDTH  = 96,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/salru_lookup.sv
// ----------------------------------------------------------------------------
// Directory lookup and update
// Tag compare over one set row, victim choice, dirty/valid/LRU row update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salru_lookup
   import salru_pkg::*;
#(
   parameter int WAYS      = WAYS_DEFAULT,
   parameter int TAG_WIDTH = TAG_WIDTH_DEFAULT,
   parameter int WAY_W     = 2,
   parameter int ROW_W     = WAYS * (TAG_WIDTH + 2 + WAY_W)
) (
   input  wire logic [ROW_W-1:0]     row_in,
   input  wire logic                 func,
   input  wire logic [TAG_WIDTH-1:0] tag,
   output      logic [ROW_W-1:0]     row_out,
   output      status_type           status,
   output      logic [WAY_W-1:0]     way
);

   localparam int VALID_LSB = WAYS * TAG_WIDTH;
   localparam int DIRTY_LSB = VALID_LSB + WAYS;
   localparam int LRU_LSB   = DIRTY_LSB + WAYS;

   logic [WAYS-1:0][TAG_WIDTH-1:0] tags;
   logic [WAYS-1:0][TAG_WIDTH-1:0] tags_new;
   logic [WAYS-1:0]                valid;
   logic [WAYS-1:0]                valid_new;
   logic [WAYS-1:0]                dirty;
   logic [WAYS-1:0]                dirty_new;
   logic [WAYS-1:0][WAY_W-1:0]     lru;
   logic [WAYS-1:0][WAY_W-1:0]     lru_new;
   logic [WAYS-1:0]                match;
   logic                           hit;
   logic [WAY_W-1:0]               hit_way;
   logic [WAY_W-1:0]               victim;
   logic [WAY_W-1:0]               sel_way;
   logic [WAY_W-1:0]               pos;
   logic                           pos_found;
   logic                           promote;

   assign tags  = row_in[VALID_LSB-1:0];
   assign valid = row_in[DIRTY_LSB-1:VALID_LSB];
   assign dirty = row_in[LRU_LSB-1:DIRTY_LSB];
   assign lru   = row_in[ROW_W-1:LRU_LSB];

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         match[w] = valid[w] && (tags[w] == tag);
      end
      hit = |match;

      // lowest matching way wins
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = WAY_W'(w);
         end
      end

      victim  = lru[WAYS-1];
      sel_way = hit ? hit_way : victim;

      pos_found = 1'b0;
      pos       = WAY_W'(WAYS - 1);
      if (hit) begin
         for (int p = WAYS - 1; p >= 0; p--) begin
            if (lru[p] == hit_way) begin
               pos_found = 1'b1;
               pos       = WAY_W'(p);
            end
         end
      end
      promote = !hit || pos_found;

      lru_new[0] = promote ? sel_way : lru[0];
      for (int p = 1; p < WAYS; p++) begin
         lru_new[p] = (promote && (WAY_W'(p) <= pos)) ? lru[p-1] : lru[p];
      end

      tags_new  = tags;
      valid_new = valid;
      dirty_new = dirty;
      if (hit) begin
         if (func == FUNC_WRITE) begin
            dirty_new[hit_way] = 1'b1;
         end
      end else begin
         tags_new[victim]  = tag;
         valid_new[victim] = 1'b1;
         dirty_new[victim] = (func == FUNC_WRITE);
      end
   end

   assign row_out      = {lru_new, dirty_new, valid_new, tags_new};
   assign status.hit   = hit;
   assign status.dirty = dirty[sel_way];
   assign way          = sel_way;

endmodule

`default_nettype wire

// File: hdl/salru_checker.sv
// ----------------------------------------------------------------------------
// Cache tag directory port checker
// Response timing and reset behavior as seen on the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "set_assoc_lru_writeback_cache_tags_macros.svh"

module salru_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_strobe
);

   `SALRU_ASSERT_NXT(a_rsp_follows, clock, reset, $past(start && !busy && !reset), rsp_strobe, "accepted item got no response two cycles later")
   `SALRU_ASSERT_IMP(a_rsp_has_item, clock, reset, rsp_strobe, $past(start && !busy && !reset, 2), "response without an accepted item")
   `SALRU_ASSERT_NXT(a_busy_after_reset, clock, 1'b0, reset, busy, "busy low right after reset")
   `SALRU_ASSERT_IMP(a_no_rsp_clearing, clock, reset, busy, !rsp_strobe, "response during clearing pass")

endmodule

bind set_assoc_lru_writeback_cache_tags salru_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

`default_nettype wire
